>>> hw/rtl/led_pixel_breathing_engine_unit_defines.svh
// assertion macros for the checker file
`ifndef LED_PIXEL_BREATHING_ENGINE_UNIT_DEFINES_SVH
`define LED_PIXEL_BREATHING_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define LPBE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define LPBE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lpbe_pkg.sv
package lpbe_pkg;

  localparam int KIND_W  = 3;
  localparam int COORD_W = 4;
  localparam int BYTE_W  = 8;
  localparam int LVL_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam int GRID_ROWS_DEF = 12;
  localparam int GRID_COLS_DEF = 12;

  localparam logic [LVL_W-1:0] MIN_RESET = 7'd10;
  localparam logic [LVL_W-1:0] MAX_RESET = 7'd80;

  localparam logic [KIND_W-1:0] KIND_WR_LEVEL  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WR_FLAGS  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET_BLINK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SET_MOVED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLR_MOVED = 3'd5;
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_BRIGHTNESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHTNESS = 1'd1;

  localparam int FLAG_MOVED_BIT = 0;
  localparam int FLAG_BLINK_BIT = 1;
  localparam int DIR_BIT        = 7;

  // one breathing step of a level byte
  function automatic logic [BYTE_W-1:0] fade_step(input logic [BYTE_W-1:0] lvl,
                                                  input logic [LVL_W-1:0] mn,
                                                  input logic [LVL_W-1:0] mx);
    logic [LVL_W-1:0] cnt;
    logic [BYTE_W-1:0] res;
    cnt = lvl[LVL_W-1:0];
    if (lvl[DIR_BIT]) begin
      res = (cnt == mn) ? {1'b0, mn} : lvl - 8'd1;
    end else begin
      res = (cnt == mx) ? {1'b1, mx} : lvl + 8'd1;
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/lpbe_ram.sv
module lpbe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 144
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/led_pixel_breathing_engine_unit.sv
// channel  dir  handshake            payload
// in       in   in_valid/in_stall    kind, col, row, value
// out      out  out_valid/out_stall  raw_level, display_level, flag_byte, is_blinking, is_moved
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// pixel item: one ram read in idle, then one write or result load in the exec state
// clear-moved and tick: a walk over every pixel, one pixel a cycle through the ram port pair
// after reset every pixel of the store is zeroed, in_stall high meanwhile
// a read waits in the exec state while the output register is full and stalled
// cfg_ready is always high
module led_pixel_breathing_engine_unit #(
  parameter int GRID_ROWS = lpbe_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = lpbe_pkg::GRID_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lpbe_pkg::KIND_W-1:0]     kind,
  input  logic [lpbe_pkg::COORD_W-1:0]    col,
  input  logic [lpbe_pkg::COORD_W-1:0]    row,
  input  logic [lpbe_pkg::BYTE_W-1:0]     value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lpbe_pkg::BYTE_W-1:0]     raw_level,
  output logic [lpbe_pkg::BYTE_W-1:0]     display_level,
  output logic [lpbe_pkg::BYTE_W-1:0]     flag_byte,
  output logic                            is_blinking,
  output logic                            is_moved,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpbe_pkg::LVL_W-1:0]      cfg_data
);

  import lpbe_pkg::*;

  localparam int PIXELS = GRID_ROWS * GRID_COLS;
  localparam int PIX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CNT_W  = $clog2(PIXELS + 1);
  localparam int WORD_W = 2 * BYTE_W;

  typedef enum logic [3:0] {
    ST_CLR  = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_WALK = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [LVL_W-1:0]  min_b, max_b;
  logic [KIND_W-1:0] op_kind;
  logic [BYTE_W-1:0] op_value;
  logic              op_ok;
  logic [PIX_W-1:0]  addr;
  logic [CNT_W-1:0]  ptr;
  logic [PIX_W-1:0]  wptr;
  logic              pend;

  logic              in_tr;
  logic              in_range;
  logic [PIX_W-1:0]  idx_in;
  logic              out_free;
  logic              load_out;

  logic              ram_we;
  logic [PIX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [BYTE_W-1:0] rd_lvl, rd_flg;
  logic [BYTE_W-1:0] new_lvl, new_flg;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_tr     = in_valid && !in_stall;
  assign in_range  = (32'(col) < GRID_COLS) && (32'(row) < GRID_ROWS);
  assign idx_in    = PIX_W'(32'(row) * GRID_COLS + 32'(col));
  assign out_free  = !out_valid || !out_stall;
  assign load_out  = (state == ST_EXEC) && (op_kind == KIND_READ) && out_free;

  assign rd_lvl = ram_rdata[BYTE_W-1:0];
  assign rd_flg = ram_rdata[WORD_W-1:BYTE_W];

  // read address: incoming pixel in idle, walk pointer in walk, held address otherwise
  always_comb begin
    case (state)
      ST_IDLE: ram_raddr = idx_in;
      ST_WALK: ram_raddr = ptr[PIX_W-1:0];
      default: ram_raddr = addr;
    endcase
  end

  // shared modify unit
  always_comb begin
    new_lvl = rd_lvl;
    new_flg = rd_flg;
    case (op_kind)
      KIND_WR_LEVEL:  new_lvl = op_value;
      KIND_WR_FLAGS:  new_flg = op_value;
      KIND_SET_BLINK: new_flg[FLAG_BLINK_BIT] = op_value[0];
      KIND_SET_MOVED: new_flg[FLAG_MOVED_BIT] = op_value[0];
      KIND_CLR_MOVED: new_flg[FLAG_MOVED_BIT] = 1'b0;
      KIND_TICK: begin
        if (rd_flg[FLAG_BLINK_BIT] && (rd_lvl >= {1'b0, min_b})) begin
          new_lvl = fade_step(rd_lvl, min_b, max_b);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = {new_flg, new_lvl};
    case (state)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr[PIX_W-1:0];
        ram_wdata = '0;
      end
      ST_EXEC: begin
        ram_we = op_ok && (op_kind == KIND_WR_LEVEL || op_kind == KIND_WR_FLAGS ||
                           op_kind == KIND_SET_BLINK || op_kind == KIND_SET_MOVED);
      end
      ST_WALK: begin
        ram_we    = pend;
        ram_waddr = wptr;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLR:  if (ptr == CNT_W'(PIXELS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_tr) begin
          state_next = (kind == KIND_CLR_MOVED || kind == KIND_TICK) ? ST_WALK : ST_EXEC;
        end
      end
      ST_EXEC: if (op_kind != KIND_READ || out_free) state_next = ST_IDLE;
      ST_WALK: if (ptr == CNT_W'(PIXELS)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      ptr       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      min_b     <= MIN_RESET;
      max_b     <= MAX_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_BRIGHTNESS: min_b <= cfg_data;
          REG_MAX_BRIGHTNESS: max_b <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_CLR: begin
          ptr <= (ptr == CNT_W'(PIXELS - 1)) ? '0 : ptr + CNT_W'(1);
        end
        ST_IDLE: begin
          ptr  <= '0;
          pend <= 1'b0;
        end
        ST_WALK: begin
          pend <= (ptr != CNT_W'(PIXELS));
          if (ptr != CNT_W'(PIXELS)) begin
            ptr <= ptr + CNT_W'(1);
          end
        end
        default: ;
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tr) begin
      op_kind  <= kind;
      op_value <= value;
      op_ok    <= in_range;
      addr     <= idx_in;
    end
    if (state == ST_WALK) begin
      wptr <= ptr[PIX_W-1:0];
    end
    if (load_out) begin
      raw_level     <= op_ok ? rd_lvl : '0;
      display_level <= !op_ok ? '0 :
                       rd_flg[FLAG_BLINK_BIT] ? {1'b0, rd_lvl[LVL_W-1:0]} : rd_lvl;
      flag_byte     <= op_ok ? rd_flg : '0;
      is_blinking   <= op_ok && rd_flg[FLAG_BLINK_BIT];
      is_moved      <= op_ok && rd_flg[FLAG_MOVED_BIT];
    end
  end

  lpbe_ram #(
    .WIDTH(WORD_W),
    .DEPTH(PIXELS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

>>> hw/rtl/lpbe_checker.sv
`include "led_pixel_breathing_engine_unit_defines.svh"

module lpbe_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [lpbe_pkg::KIND_W-1:0]     kind,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [lpbe_pkg::BYTE_W-1:0]     raw_level,
  input logic [lpbe_pkg::BYTE_W-1:0]     display_level,
  input logic [lpbe_pkg::BYTE_W-1:0]     flag_byte,
  input logic                            is_blinking,
  input logic                            is_moved
);

  import lpbe_pkg::*;

  // one transaction at a time
  `LPBE_ASSERT_NXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input taken while busy")

  // a fresh result only follows an accepted read transaction
  `LPBE_ASSERT_IMP(a_result_from_read, $rose(out_valid), $past(in_valid && !in_stall && kind == KIND_READ, 2), "result without read")

  // held result stays put
  `LPBE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(raw_level) && $stable(flag_byte), "stalled result changed")

  // result fields agree with each other
  `LPBE_ASSERT_IMP(a_fields_agree, out_valid, is_blinking == flag_byte[FLAG_BLINK_BIT] && is_moved == flag_byte[FLAG_MOVED_BIT] && display_level == (is_blinking ? {1'b0, raw_level[LVL_W-1:0]} : raw_level), "result fields disagree")

endmodule

bind led_pixel_breathing_engine_unit lpbe_checker u_lpbe_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .kind         (kind),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .raw_level    (raw_level),
  .display_level(display_level),
  .flag_byte    (flag_byte),
  .is_blinking  (is_blinking),
  .is_moved     (is_moved)
);

>>> tb/sv/led_pixel_breathing_engine_unit_tb.sv
module led_pixel_breathing_engine_unit_tb;
  import lpbe_pkg::*;

  localparam int GRID_R = GRID_ROWS_DEF;
  localparam int GRID_C = GRID_COLS_DEF;
  localparam int PIXELS = GRID_R * GRID_C;
  localparam int LONG_HOLD = 400;
  localparam int LIMIT_CYCLES = 600000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] raw_level;
    logic [BYTE_W-1:0] display_level;
    logic [BYTE_W-1:0] flag_byte;
    logic              is_blinking;
    logic              is_moved;
  } pixel_view_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    kind = KIND_WR_LEVEL;
  logic [COORD_W-1:0]   col = '0;
  logic [COORD_W-1:0]   row = '0;
  logic [BYTE_W-1:0]    value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    raw_level;
  logic [BYTE_W-1:0]    display_level;
  logic [BYTE_W-1:0]    flag_byte;
  logic                 is_blinking;
  logic                 is_moved;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MIN_BRIGHTNESS;
  logic [LVL_W-1:0]     cfg_data = '0;

  // grid copy kept alongside the block
  logic [BYTE_W-1:0] level_mem [0:PIXELS-1];
  logic [BYTE_W-1:0] flag_mem  [0:PIXELS-1];
  logic [LVL_W-1:0]  fade_min;
  logic [LVL_W-1:0]  fade_max;
  pixel_view_t       pending_reads[$];

  int fail_count = 0;
  int cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  led_pixel_breathing_engine_unit DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .col(col),
    .row(row),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .raw_level(raw_level),
    .display_level(display_level),
    .flag_byte(flag_byte),
    .is_blinking(is_blinking),
    .is_moved(is_moved),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stall pattern, or one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(16, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic logic [BYTE_W-1:0] breathe(input logic [BYTE_W-1:0] lvl);
    logic [BYTE_W-1:0] nxt;
    if (lvl[DIR_BIT]) begin
      if (lvl[LVL_W-1:0] == fade_min) nxt = {1'b0, fade_min};
      else nxt = lvl - 8'd1;
    end else begin
      if (lvl[LVL_W-1:0] == fade_max) nxt = {1'b1, fade_max};
      else nxt = lvl + 8'd1;
    end
    return nxt;
  endfunction

  task automatic track_item(input logic [KIND_W-1:0] k, input logic [COORD_W-1:0] c,
                            input logic [COORD_W-1:0] r, input logic [BYTE_W-1:0] v);
    bit on_grid;
    int idx;
    pixel_view_t view;
    on_grid = (c < GRID_C) && (r < GRID_R);
    idx = r * GRID_C + c;
    case (k)
      KIND_WR_LEVEL: if (on_grid) level_mem[idx] = v;
      KIND_WR_FLAGS: if (on_grid) flag_mem[idx] = v;
      KIND_SET_BLINK: if (on_grid) flag_mem[idx][FLAG_BLINK_BIT] = v[0];
      KIND_SET_MOVED: if (on_grid) flag_mem[idx][FLAG_MOVED_BIT] = v[0];
      KIND_READ: begin
        view = '0;
        if (on_grid) begin
          view.raw_level = level_mem[idx];
          view.flag_byte = flag_mem[idx];
          view.is_blinking = flag_mem[idx][FLAG_BLINK_BIT];
          view.is_moved = flag_mem[idx][FLAG_MOVED_BIT];
          view.display_level = level_mem[idx];
          if (view.is_blinking) view.display_level[DIR_BIT] = 1'b0;
        end
        pending_reads.push_back(view);
      end
      KIND_CLR_MOVED: begin
        for (int i = 0; i < PIXELS; i++) flag_mem[i][FLAG_MOVED_BIT] = 1'b0;
      end
      KIND_TICK: begin
        for (int i = 0; i < PIXELS; i++) begin
          if (level_mem[i] >= {1'b0, fade_min} && flag_mem[i][FLAG_BLINK_BIT])
            level_mem[i] = breathe(level_mem[i]);
        end
      end
      default: ;
    endcase
  endtask

  // sender: bursts of random length, with random gaps between them while gaps_on is set
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [COORD_W-1:0] c,
                           input logic [COORD_W-1:0] r, input logic [BYTE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    kind <= k;
    col <= c;
    row <= r;
    value <= v;
    do @(posedge clk); while (in_stall);
    track_item(k, c, r, v);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (PIXELS + 8) @(posedge clk);
  endtask

  task automatic set_fade(input logic [LVL_W-1:0] lo, input logic [LVL_W-1:0] hi);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_MIN_BRIGHTNESS;
    cfg_data <= lo;
    do @(posedge clk); while (!cfg_ready);
    fade_min = lo;
    cfg_index <= REG_MAX_BRIGHTNESS;
    cfg_data <= hi;
    do @(posedge clk); while (!cfg_ready);
    fade_max = hi;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    pixel_view_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $error("result transaction with no read outstanding");
        fail_count++;
      end else begin
        want = pending_reads.pop_front();
        check_field("raw_level", want.raw_level, raw_level);
        check_field("display_level", want.display_level, display_level);
        check_field("flag_byte", want.flag_byte, flag_byte);
        check_field("is_blinking", 8'(want.is_blinking), 8'(is_blinking));
        check_field("is_moved", 8'(want.is_moved), 8'(is_moved));
      end
    end
  end

  task automatic test_reset_state();
    send_item(KIND_READ, 4'd0, 4'd0, 8'h00);
    send_item(KIND_READ, 4'd11, 4'd11, 8'hFF);
  endtask

  task automatic test_pixel_ops();
    send_item(KIND_WR_LEVEL, 4'd0, 4'd0, 8'hFF);
    send_item(KIND_WR_FLAGS, 4'd0, 4'd0, 8'hFF);
    send_item(KIND_READ, 4'd0, 4'd0, 8'h00);
    send_item(KIND_SET_BLINK, 4'd0, 4'd0, 8'hFE);
    send_item(KIND_SET_MOVED, 4'd11, 4'd11, 8'h01);
    send_item(KIND_CLR_MOVED, 4'd5, 4'd5, 8'hA5);
    send_item(KIND_UNUSED, 4'd0, 4'd0, 8'h00);
    send_item(KIND_READ, 4'd0, 4'd0, 8'h00);
    send_item(KIND_READ, 4'd11, 4'd11, 8'h00);
    // off-grid writes must not alias onto real pixels
    send_item(KIND_WR_LEVEL, 4'd12, 4'd0, 8'hAA);
    send_item(KIND_WR_FLAGS, 4'd15, 4'd15, 8'hFF);
    send_item(KIND_SET_BLINK, 4'd0, 4'd12, 8'h01);
    send_item(KIND_READ, 4'd12, 4'd0, 8'h00);
    send_item(KIND_READ, 4'd0, 4'd1, 8'h00);
    send_item(KIND_READ, 4'd15, 4'd15, 8'h00);
  endtask

  task automatic test_fade_turning();
    set_fade(7'd10, 7'd12);
    send_item(KIND_WR_LEVEL, 4'd3, 4'd4, 8'h0B);
    send_item(KIND_SET_BLINK, 4'd3, 4'd4, 8'h03);
    send_item(KIND_WR_LEVEL, 4'd4, 4'd4, 8'h05);
    send_item(KIND_SET_BLINK, 4'd4, 4'd4, 8'h01);
    send_item(KIND_WR_LEVEL, 4'd5, 4'd4, 8'h80);
    send_item(KIND_SET_BLINK, 4'd5, 4'd4, 8'hFF);
    send_item(KIND_WR_LEVEL, 4'd6, 4'd4, 8'h8A);
    send_item(KIND_SET_BLINK, 4'd6, 4'd4, 8'h01);
    repeat (3) begin
      send_item(KIND_TICK, 4'd0, 4'd0, 8'h00);
      send_item(KIND_READ, 4'd3, 4'd4, 8'h00);
    end
    send_item(KIND_READ, 4'd4, 4'd4, 8'h00);
    send_item(KIND_READ, 4'd5, 4'd4, 8'h00);
    send_item(KIND_READ, 4'd6, 4'd4, 8'h00);
    set_fade(7'd0, 7'd127);
    send_item(KIND_TICK, 4'd0, 4'd0, 8'h00);
    send_item(KIND_READ, 4'd3, 4'd4, 8'h00);
    set_fade(7'd127, 7'd0);
    send_item(KIND_TICK, 4'd0, 4'd0, 8'h00);
    send_item(KIND_READ, 4'd3, 4'd4, 8'h00);
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req <= 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 3) send_item(KIND_WR_LEVEL, 4'($urandom_range(0, 2)), 4'd1, 8'($urandom));
      else send_item(KIND_READ, 4'($urandom_range(0, 2)), 4'd1, 8'h00);
    end
    gaps_on = 1'b1;
  endtask

  task automatic random_items(input int n);
    int sent;
    int pick;
    int steps;
    logic [KIND_W-1:0] k;
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] r;
    logic [BYTE_W-1:0] v;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // breathing run on one pixel, level mostly placed near a turning point
        c = 4'($urandom_range(0, GRID_C - 1));
        r = 4'($urandom_range(0, GRID_R - 1));
        case ($urandom_range(0, 3))
          0: v = {1'b0, fade_min} + 8'($urandom_range(0, 2));
          1: v = {1'b0, fade_max} - 8'($urandom_range(0, 2));
          2: v = {1'b1, fade_min} + 8'($urandom_range(0, 2));
          default: v = 8'($urandom);
        endcase
        send_item(KIND_WR_LEVEL, c, r, v);
        send_item(KIND_SET_BLINK, c, r, 8'($urandom) | 8'h01);
        steps = $urandom_range(1, 4);
        repeat (steps) begin
          send_item(KIND_TICK, 4'($urandom), 4'($urandom), 8'($urandom));
          send_item(KIND_READ, c, r, 8'($urandom));
        end
        sent += 2 + 2 * steps;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 18) k = KIND_WR_LEVEL;
        else if (pick < 28) k = KIND_WR_FLAGS;
        else if (pick < 42) k = KIND_SET_BLINK;
        else if (pick < 52) k = KIND_SET_MOVED;
        else if (pick < 86) k = KIND_READ;
        else if (pick < 89) k = KIND_CLR_MOVED;
        else if (pick < 96) k = KIND_TICK;
        else k = KIND_UNUSED;
        if ($urandom_range(0, 9) == 0) begin
          c = 4'($urandom);
          r = 4'($urandom);
        end else if ($urandom_range(0, 1) == 1) begin
          c = 4'($urandom_range(0, 2));
          r = 4'($urandom_range(0, 2));
        end else begin
          c = 4'($urandom_range(0, GRID_C - 1));
          r = 4'($urandom_range(0, GRID_R - 1));
        end
        send_item(k, c, r, 8'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random();
    set_fade(7'd10, 7'd80);
    gaps_on = 1'b1;
    random_items(64);
    set_fade(7'd0, 7'd127);
    gaps_on = 1'b0;
    random_items(64);
    set_fade(7'd127, 7'd0);
    gaps_on = 1'b1;
    random_items(64);
    set_fade(7'd40, 7'd40);
    random_items(64);
    set_fade(7'($urandom_range(0, 60)), 7'($urandom_range(61, 127)));
    gaps_on = ($urandom_range(0, 1) == 1);
    random_items(64);
  endtask

  initial begin
    for (int i = 0; i < PIXELS; i++) begin
      level_mem[i] = '0;
      flag_mem[i] = '0;
    end
    fade_min = MIN_RESET;
    fade_max = MAX_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_pixel_ops();
    test_fade_turning();
    test_backpressure();
    test_random();
    settle_idle();
    if (pending_reads.size() != 0) begin
      $error("%0d read transactions never answered", pending_reads.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
